/* src/hcg_pkg.sv */
// Shared types and constants of the height-to-color gradient block.
// No dependencies; the interfaces and the core take names from here.
package hcg_pkg;

  localparam int HEIGHT_BITS_DEFAULT = 16;
  localparam int COLOR_BITS          = 24;
  localparam int CHAN_BITS           = 8;
  localparam int NUM_CHANS           = 3;
  localparam int REG_INDEX_BITS      = 3;

  localparam logic [COLOR_BITS-1:0] MIDDLE_COLOR_RESET = 24'h000000;
  localparam logic [COLOR_BITS-1:0] TOP_COLOR_RESET    = 24'hFFFFFF;
  localparam logic [COLOR_BITS-1:0] BOTTOM_COLOR_RESET = 24'h0000FF;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_MIDDLE_COLOR  = 3'd0,
    REG_TOP_COLOR     = 3'd1,
    REG_BOTTOM_COLOR  = 3'd2,
    REG_HEIGHT_TOP    = 3'd3,
    REG_HEIGHT_BOTTOM = 3'd4
  } reg_index_t;

endpackage

/* src/hcg_point_if.sv */
// Input channel: one map point per item (signed height, end-of-map mark).
// Depends on hcg_pkg for the default height width.
interface hcg_point_if #(
  parameter int HEIGHT_BITS = hcg_pkg::HEIGHT_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height;
  logic                          end_of_map;

  modport source (output valid, output height, output end_of_map, input ready);
  modport sink   (input valid, input height, input end_of_map, output ready);
endinterface

/* src/hcg_pixel_if.sv */
// Output channel: one blended RGB color per item plus the end-of-map mark.
// Depends on hcg_pkg for the color width.
interface hcg_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [hcg_pkg::COLOR_BITS-1:0] pixel_color;
  logic                           end_of_map_out;

  modport source (output valid, output pixel_color, output end_of_map_out, input ready);
  modport sink   (input valid, input pixel_color, input end_of_map_out, output ready);
endinterface

/* src/height_to_color_gradient_core.sv */
// Height-to-color gradient: maps each signed map height to a blended RGB color.
// Depends on hcg_pkg, hcg_point_if and hcg_pixel_if.
//
// Usage:
//   points  - input items, one signed height and an end-of-map mark each.
//   pixels  - output items, one 24-bit color (red 23:16) and the copied mark.
//   write_enable / write_index / write_data - register writes: 0 middle color,
//     1 top color, 2 bottom color, 3 height_top, 4 height_bottom. Write only
//     while no item is in flight.
// Zero height gives the middle color; a positive height blends toward the top
// color by height/height_top, a negative one toward the bottom color by
// height/height_bottom, each channel rounded half up, saturating at the end
// color. The blend is mid*(d-n) + end*n over d, divided by an 8-stage
// restoring divider, one quotient bit per stage.
// An accepted item passes stage A, stage B and the divider stages to the pixels port.
// Throughput: one item per cycle. Each stage holds when the next is full and
// stalled, so bubbles collapse and the input keeps accepting until all ten
// stages hold items while the receiver stalls.
// Reset (synchronous, rst high) empties the pipeline and loads the register
// defaults: black middle, white top, blue bottom, both divisors of magnitude 1.
module height_to_color_gradient_core #(
  parameter int HEIGHT_BITS = hcg_pkg::HEIGHT_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 write_enable,
  input  logic [hcg_pkg::REG_INDEX_BITS-1:0]   write_index,
  input  logic [((HEIGHT_BITS > hcg_pkg::COLOR_BITS) ? HEIGHT_BITS
                 : hcg_pkg::COLOR_BITS)-1:0]   write_data,
  hcg_point_if.sink                            points,
  hcg_pixel_if.source                          pixels
);

  localparam int HB        = HEIGHT_BITS;
  localparam int CB        = hcg_pkg::COLOR_BITS;
  localparam int CH        = hcg_pkg::CHAN_BITS;
  localparam int NC        = hcg_pkg::NUM_CHANS;
  localparam int PW        = HB + CH;
  localparam int NW        = PW + 1;
  localparam int DIV_STEPS = CH;
  localparam int NS        = 2 + DIV_STEPS;

  // Configuration registers
  logic [CB-1:0]        middle_color;
  logic [CB-1:0]        top_color;
  logic [CB-1:0]        bottom_color;
  logic [HB-2:0]        height_top;
  logic signed [HB-1:0] height_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      middle_color  <= hcg_pkg::MIDDLE_COLOR_RESET;
      top_color     <= hcg_pkg::TOP_COLOR_RESET;
      bottom_color  <= hcg_pkg::BOTTOM_COLOR_RESET;
      height_top    <= (HB-1)'(1);
      height_bottom <= '1;
    end else if (write_enable) begin
      case (hcg_pkg::reg_index_t'(write_index))
        hcg_pkg::REG_MIDDLE_COLOR:  middle_color  <= write_data[CB-1:0];
        hcg_pkg::REG_TOP_COLOR:     top_color     <= write_data[CB-1:0];
        hcg_pkg::REG_BOTTOM_COLOR:  bottom_color  <= write_data[CB-1:0];
        hcg_pkg::REG_HEIGHT_TOP:    height_top    <= write_data[HB-2:0];
        hcg_pkg::REG_HEIGHT_BOTTOM: height_bottom <= write_data[HB-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic [NS-1:0] valid;
  logic [NS-1:0] load;

  always_comb begin
    logic chain;
    chain = pixels.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      load[i] = !valid[i] || chain;
      chain   = load[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) valid[0] <= points.valid;
      for (int i = 1; i < NS; i++) begin
        if (load[i]) valid[i] <= valid[i-1];
      end
    end
  end

  assign points.ready = load[0];

  // Stage A: pick side, fraction n/d with n <= d and d >= 1, and end color
  logic [HB-1:0] z_bits, n_raw, d_raw, hb_mag;
  logic          z_neg, z_zero;
  logic [HB-1:0] a_n_next, a_d_next;
  logic [CB-1:0] a_end_next;

  logic [HB-1:0] a_n, a_d;
  logic [CB-1:0] a_mid, a_end;
  logic          a_eom;

  always_comb begin
    z_bits = points.height;
    z_neg  = z_bits[HB-1];
    z_zero = (z_bits == '0);
    n_raw  = z_neg ? (~z_bits + 1'b1) : z_bits;
    hb_mag = height_bottom[HB-1] ? (~height_bottom + 1'b1) : height_bottom;
    d_raw  = z_neg ? hb_mag : {1'b0, height_top};
    a_end_next = z_neg ? bottom_color : top_color;
    if (z_zero) begin
      a_n_next   = '0;
      a_d_next   = HB'(1);
      a_end_next = middle_color;
    end else if (d_raw == '0 || n_raw > d_raw) begin
      a_n_next = HB'(1);
      a_d_next = HB'(1);
    end else begin
      a_n_next = n_raw;
      a_d_next = d_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      a_n   <= a_n_next;
      a_d   <= a_d_next;
      a_mid <= middle_color;
      a_end <= a_end_next;
      a_eom <= points.end_of_map;
    end
  end

  // Stage B: numerator 2*(mid*(d-n) + end*n) + d per channel
  logic [HB-1:0] ab_diff;
  logic [PW-1:0] b_prod [0:NC-1];
  logic [NW-1:0] b_num_next [0:NC-1];
  logic [NW-1:0] b_num [0:NC-1];
  logic [HB-1:0] b_d;
  logic          b_eom;

  always_comb begin
    ab_diff = a_d - a_n;
    for (int c = 0; c < NC; c++) begin
      b_prod[c] = PW'(a_mid[c*CH +: CH]) * PW'(ab_diff)
                + PW'(a_end[c*CH +: CH]) * PW'(a_n);
      b_num_next[c] = {b_prod[c], 1'b0} + NW'(a_d);
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      for (int c = 0; c < NC; c++) b_num[c] <= b_num_next[c];
      b_d   <= a_d;
      b_eom <= a_eom;
    end
  end

  // Divider stages: one quotient bit per stage, most significant first
  logic [NW-1:0] div_rem [0:DIV_STEPS-1][0:NC-1];
  logic [CH-1:0] div_quo [0:DIV_STEPS-1][0:NC-1];
  logic [HB-1:0] div_d   [0:DIV_STEPS-1];
  logic          div_eom [0:DIV_STEPS-1];

  genvar s;
  generate
    for (s = 0; s < DIV_STEPS; s++) begin : g_div
      localparam int K = DIV_STEPS - 1 - s;
      logic [NW-1:0] in_rem [0:NC-1];
      logic [CH-1:0] in_quo [0:NC-1];
      logic [HB-1:0] in_d;
      logic          in_eom;
      logic [NW-1:0] step_div;
      logic [NW-1:0] rem_next [0:NC-1];
      logic [CH-1:0] quo_next [0:NC-1];

      if (s == 0) begin : g_first
        always_comb begin
          for (int c = 0; c < NC; c++) begin
            in_rem[c] = b_num[c];
            in_quo[c] = '0;
          end
          in_d   = b_d;
          in_eom = b_eom;
        end
      end else begin : g_rest
        always_comb begin
          for (int c = 0; c < NC; c++) begin
            in_rem[c] = div_rem[s-1][c];
            in_quo[c] = div_quo[s-1][c];
          end
          in_d   = div_d[s-1];
          in_eom = div_eom[s-1];
        end
      end

      always_comb begin
        step_div = NW'(in_d) << (K + 1);
        for (int c = 0; c < NC; c++) begin
          if (in_rem[c] >= step_div) begin
            rem_next[c] = in_rem[c] - step_div;
            quo_next[c] = {in_quo[c][CH-2:0], 1'b1};
          end else begin
            rem_next[c] = in_rem[c];
            quo_next[c] = {in_quo[c][CH-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (load[s+2]) begin
          for (int c = 0; c < NC; c++) begin
            div_rem[s][c] <= rem_next[c];
            div_quo[s][c] <= quo_next[c];
          end
          div_d[s]   <= in_d;
          div_eom[s] <= in_eom;
        end
      end
    end
  endgenerate

  assign pixels.valid          = valid[NS-1];
  assign pixels.pixel_color    = {div_quo[DIV_STEPS-1][2], div_quo[DIV_STEPS-1][1],
                                  div_quo[DIV_STEPS-1][0]};
  assign pixels.end_of_map_out = div_eom[DIV_STEPS-1];

  // Checks
  a_fraction_bounded: assert property (@(posedge clk) disable iff (rst)
    valid[0] |-> (a_d != '0 && a_n <= a_d))
    else $error("fraction numerator exceeds divisor");

  a_remainder_bounded: assert property (@(posedge clk) disable iff (rst)
    valid[NS-1] |-> (div_rem[DIV_STEPS-1][0] < {div_d[DIV_STEPS-1], 1'b0}
                  && div_rem[DIV_STEPS-1][1] < {div_d[DIV_STEPS-1], 1'b0}
                  && div_rem[DIV_STEPS-1][2] < {div_d[DIV_STEPS-1], 1'b0}))
    else $error("divider remainder out of range");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (valid == '1 && !pixels.ready) |-> !points.ready)
    else $error("input accepted while pipeline full and stalled");

endmodule

/* dv/height_to_color_gradient_core_tb.sv */
`timescale 1ns / 100ps
// Testbench of height_to_color_gradient_core: sends map points with random gaps,
// predicts each blended color and checks the pixel stream in order.
// Depends on hcg_pkg, hcg_point_if, hcg_pixel_if and the core.
module height_to_color_gradient_core_tb;

  localparam int HEIGHT_BITS = hcg_pkg::HEIGHT_BITS_DEFAULT;
  localparam int WRITE_BITS = (HEIGHT_BITS > hcg_pkg::COLOR_BITS) ? HEIGHT_BITS
                                                                  : hcg_pkg::COLOR_BITS;
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 6;
  localparam int POINTS_PER_PHASE = 100;

  typedef struct packed {
    logic [hcg_pkg::COLOR_BITS-1:0] color;
    logic                           end_of_map;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic write_enable;
  logic [hcg_pkg::REG_INDEX_BITS-1:0] write_index;
  logic [WRITE_BITS-1:0] write_data;

  hcg_point_if #(.HEIGHT_BITS(HEIGHT_BITS)) points ();
  hcg_pixel_if pixels ();

  height_to_color_gradient_core #(.HEIGHT_BITS(HEIGHT_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .write_index(write_index),
    .write_data(write_data),
    .points(points),
    .pixels(pixels)
  );

  logic [hcg_pkg::COLOR_BITS-1:0] cfg_middle = hcg_pkg::MIDDLE_COLOR_RESET;
  logic [hcg_pkg::COLOR_BITS-1:0] cfg_top = hcg_pkg::TOP_COLOR_RESET;
  logic [hcg_pkg::COLOR_BITS-1:0] cfg_bottom = hcg_pkg::BOTTOM_COLOR_RESET;
  logic [HEIGHT_BITS-2:0] cfg_height_top = 1;
  logic signed [HEIGHT_BITS-1:0] cfg_height_bottom = -1;

  pixel_t pending_pixels[$];
  int mismatch_count = 0;
  int gap_max = 0;
  int stall_max = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  function automatic logic [hcg_pkg::CHAN_BITS-1:0] blend_channel(
      logic [hcg_pkg::CHAN_BITS-1:0] mid, logic [hcg_pkg::CHAN_BITS-1:0] tgt,
      longint n, longint d);
    longint num;
    num = 2 * longint'(mid) * d + 2 * (longint'(tgt) - longint'(mid)) * n + d;
    return hcg_pkg::CHAN_BITS'(num / (2 * d));
  endfunction

  function automatic logic [hcg_pkg::COLOR_BITS-1:0] blend_color(
      logic [hcg_pkg::COLOR_BITS-1:0] mid, logic [hcg_pkg::COLOR_BITS-1:0] tgt,
      longint n, longint d);
    logic [hcg_pkg::COLOR_BITS-1:0] color;
    if (d <= 0) begin
      n = 1;
      d = 1;
    end
    if (n > d) n = d;
    for (int c = 0; c < hcg_pkg::NUM_CHANS; c++)
      color[c*hcg_pkg::CHAN_BITS +: hcg_pkg::CHAN_BITS] =
        blend_channel(mid[c*hcg_pkg::CHAN_BITS +: hcg_pkg::CHAN_BITS],
                      tgt[c*hcg_pkg::CHAN_BITS +: hcg_pkg::CHAN_BITS], n, d);
    return color;
  endfunction

  function automatic logic [hcg_pkg::COLOR_BITS-1:0] predict_color(
      logic signed [HEIGHT_BITS-1:0] h);
    longint z;
    longint d;
    z = longint'(h);
    if (z == 0) return cfg_middle;
    if (z > 0) return blend_color(cfg_middle, cfg_top, z, longint'(cfg_height_top));
    d = longint'(cfg_height_bottom);
    if (d < 0) d = -d;
    return blend_color(cfg_middle, cfg_bottom, -z, d);
  endfunction

  function automatic logic [hcg_pkg::COLOR_BITS-1:0] pick_color();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return hcg_pkg::COLOR_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [WRITE_BITS-1:0] pick_height_top();
    logic [HEIGHT_BITS-2:0] value;
    logic [WRITE_BITS-1:0] data;
    case ($urandom_range(0, 7))
      0: value = '0;
      1: value = '1;
      2: value = (HEIGHT_BITS-1)'(1);
      3: value = (HEIGHT_BITS-1)'($urandom_range(2, 15));
      default: value = (HEIGHT_BITS-1)'($urandom_range(1, 32767));
    endcase
    data = WRITE_BITS'($urandom);
    data[HEIGHT_BITS-2:0] = value;
    return data;
  endfunction

  function automatic logic [WRITE_BITS-1:0] pick_height_bottom();
    logic signed [HEIGHT_BITS-1:0] value;
    logic [WRITE_BITS-1:0] data;
    case ($urandom_range(0, 7))
      0: value = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
      1: value = '1;
      2: value = '0;
      3: value = HEIGHT_BITS'($urandom_range(1, 32767));
      4: value = HEIGHT_BITS'(-longint'($urandom_range(1, 15)));
      default: value = HEIGHT_BITS'(-longint'($urandom_range(1, 32768)));
    endcase
    data = WRITE_BITS'($urandom);
    data[HEIGHT_BITS-1:0] = value;
    return data;
  endfunction

  function automatic logic signed [HEIGHT_BITS-1:0] pick_height();
    logic negative;
    longint span;
    int mag;
    negative = 1'($urandom_range(0, 1));
    span = negative ? longint'(cfg_height_bottom) : longint'(cfg_height_top);
    if (span < 0) span = -span;
    if (span < 1) span = 1;
    case ($urandom_range(0, 9))
      5, 6: return HEIGHT_BITS'($urandom);
      8: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      9: return '0;
      7: mag = int'($urandom_range(1, 15));
      default: mag = int'($urandom_range(1, 32'(span)));
    endcase
    return HEIGHT_BITS'(negative ? -mag : mag);
  endfunction

  always @(posedge clk) begin : check_pixels
    pixel_t accepted;
    pixel_t wanted;
    if (!rst) begin
      if (points.valid && points.ready) begin
        wanted.color = predict_color(points.height);
        wanted.end_of_map = points.end_of_map;
        pending_pixels.push_back(wanted);
      end
      if (pixels.valid && pixels.ready) begin
        accepted.color = pixels.pixel_color;
        accepted.end_of_map = pixels.end_of_map_out;
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel color %h end_of_map %b", $time,
                   accepted.color, accepted.end_of_map);
          mismatch_count++;
        end else begin
          wanted = pending_pixels.pop_front();
          if (accepted.color !== wanted.color) begin
            $display("%0t: pixel_color expected %h got %h", $time, wanted.color,
                     accepted.color);
            mismatch_count++;
          end
          if (accepted.end_of_map !== wanted.end_of_map) begin
            $display("%0t: end_of_map_out expected %b got %b", $time, wanted.end_of_map,
                     accepted.end_of_map);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((points.valid && points.ready) || (pixels.valid && pixels.ready) || write_enable)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : accept_pixels
    int stall;
    pixels.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, stall_max);
      @(negedge clk);
      if (stall > 0) begin
        pixels.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pixels.ready <= 1'b1;
      do @(posedge clk); while (!pixels.valid);
    end
  end

  task automatic send_point(logic signed [HEIGHT_BITS-1:0] height, logic end_of_map);
    int gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap > 0) begin
      points.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    points.valid <= 1'b1;
    points.height <= height;
    points.end_of_map <= end_of_map;
    do @(posedge clk); while (!points.ready);
  endtask

  task automatic wait_for_pixels();
    @(negedge clk);
    points.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(hcg_pkg::reg_index_t index, logic [WRITE_BITS-1:0] value);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index <= index;
    write_data <= value;
    @(posedge clk);
    case (index)
      hcg_pkg::REG_MIDDLE_COLOR:  cfg_middle = value[hcg_pkg::COLOR_BITS-1:0];
      hcg_pkg::REG_TOP_COLOR:     cfg_top = value[hcg_pkg::COLOR_BITS-1:0];
      hcg_pkg::REG_BOTTOM_COLOR:  cfg_bottom = value[hcg_pkg::COLOR_BITS-1:0];
      hcg_pkg::REG_HEIGHT_TOP:    cfg_height_top = value[HEIGHT_BITS-2:0];
      hcg_pkg::REG_HEIGHT_BOTTOM: cfg_height_bottom = value[HEIGHT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_palette(logic [hcg_pkg::COLOR_BITS-1:0] mid_color,
                              logic [hcg_pkg::COLOR_BITS-1:0] top_color,
                              logic [hcg_pkg::COLOR_BITS-1:0] bottom_color,
                              logic [WRITE_BITS-1:0] top_height,
                              logic [WRITE_BITS-1:0] bottom_height);
    wait_for_pixels();
    write_register(hcg_pkg::REG_MIDDLE_COLOR, mid_color);
    write_register(hcg_pkg::REG_TOP_COLOR, top_color);
    write_register(hcg_pkg::REG_BOTTOM_COLOR, bottom_color);
    write_register(hcg_pkg::REG_HEIGHT_TOP, top_height);
    write_register(hcg_pkg::REG_HEIGHT_BOTTOM, bottom_height);
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic test_reset_palette();
    gap_max = 0;
    stall_max = 0;
    send_point(0, 1'b0);
    send_point(1, 1'b0);
    send_point(16'h7FFF, 1'b0);
    send_point(-1, 1'b0);
    send_point(16'h8000, 1'b1);
  endtask

  task automatic test_gradient_extremes();
    gap_max = 15;
    stall_max = 15;
    load_palette(24'h7F80FF, 24'hFF00FF, 24'h00FF00, 24'h007FFF, 24'h008000);
    send_point(16384, 1'b0);
    send_point(16'h7FFF, 1'b0);
    send_point(-16384, 1'b0);
    send_point(16'h8000, 1'b0);
    send_point(1, 1'b0);
    send_point(-1, 1'b1);
  endtask

  task automatic test_rounding_and_saturation();
    gap_max = 0;
    stall_max = 15;
    load_palette(24'h000000, 24'h010101, 24'hFFFFFF, 24'h000002, 24'h00FFFE);
    send_point(1, 1'b0);
    send_point(2, 1'b0);
    send_point(5, 1'b0);
    send_point(-1, 1'b0);
    send_point(16'h8000, 1'b1);
  endtask

  task automatic test_degenerate_divisors();
    gap_max = 15;
    stall_max = 0;
    load_palette(24'h123456, 24'hABCDEF, 24'h0F0F0F, 24'h000000, 24'h000000);
    send_point(7, 1'b0);
    send_point(-7, 1'b0);
    send_point(0, 1'b0);
    load_palette(24'h123456, 24'hABCDEF, 24'h0F0F0F, 24'h000000, 24'h000064);
    send_point(-50, 1'b0);
    send_point(-100, 1'b0);
    send_point(-200, 1'b1);
  endtask

  task automatic test_random_maps();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_palette(pick_color(), pick_color(), pick_color(), pick_height_top(),
                   pick_height_bottom());
      gap_max = (phase % 2) ? 15 : 0;
      stall_max = ((phase / 2) % 2) ? 15 : 0;
      for (int i = 0; i < POINTS_PER_PHASE; i++) begin
        if ($urandom_range(0, 63) == 0) wait_for_pixels();
        send_point(pick_height(), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    write_enable = 1'b0;
    write_index = hcg_pkg::REG_MIDDLE_COLOR;
    write_data = '0;
    points.valid = 1'b0;
    points.height = '0;
    points.end_of_map = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_palette();
    test_gradient_extremes();
    test_rounding_and_saturation();
    test_degenerate_divisors();
    test_random_maps();

    wait_for_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
